// File: design/gba_pkg.sv
// Shared constants, types and helpers for the two-body gravity acceleration unit.
package gba_pkg;

    localparam int POS_BITS      = 48;
    localparam int ACC_FRAC_BITS = 32;

    localparam int POS_W    = 48;
    localparam int GP_W     = 52;
    localparam int OUT_W    = 64;
    localparam int NCOMP    = 3;

    localparam int Q_W      = 2 * POS_BITS + 2;
    localparam int SQ_IN_W  = Q_W + 32;
    localparam int SQ_ITER  = SQ_IN_W / 2;
    localparam int S_W      = POS_BITS + 17;
    localparam int DEN_W    = Q_W + S_W;
    localparam int PROD_W   = GP_W + POS_BITS;
    localparam int NUM_SH   = ACC_FRAC_BITS + 16;
    localparam int NUM_W    = PROD_W + NUM_SH;
    localparam int CNT_W    = $clog2(NUM_W + 1);

    localparam logic [GP_W-1:0] GP_RESET = GP_W'(64'd398600441800000);

    localparam logic [OUT_W-1:0] SMAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SMIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CHK,
        ST_SQRT,
        ST_DEN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } gba_state_t;

    typedef struct packed {
        logic done;
        logic zero_pos;
        logic clip;
    } gba_stat_t;

    typedef struct packed {
        logic [OUT_W-1:0] sum;
        logic             clip;
    } gba_sat_t;

    function automatic gba_sat_t sat_add(input logic [OUT_W-1:0] a, input logic [OUT_W-1:0] b);
        gba_sat_t         r;
        logic [OUT_W-1:0] s;
        s = a + b;
        r.sum  = s;
        r.clip = 1'b0;
        if (a[OUT_W-1] == b[OUT_W-1] && s[OUT_W-1] != a[OUT_W-1])
        begin
            r.clip = 1'b1;
            r.sum  = a[OUT_W-1] ? SMIN : SMAX;
        end
        return r;
    endfunction

endpackage

// File: design/gba_core.sv
// Sequenced datapath: squared norm, square root, r cubed and per-axis division.
module gba_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          take,
    input  logic [gba_pkg::POS_W-1:0]     pos_x,
    input  logic [gba_pkg::POS_W-1:0]     pos_y,
    input  logic [gba_pkg::POS_W-1:0]     pos_z,
    input  logic [gba_pkg::GP_W-1:0]      grav_param,
    output gba_pkg::gba_stat_t            stat,
    output logic [gba_pkg::OUT_W-1:0]     acc_x,
    output logic [gba_pkg::OUT_W-1:0]     acc_y,
    output logic [gba_pkg::OUT_W-1:0]     acc_z
);

    localparam int P  = gba_pkg::POS_BITS;
    localparam int OW = gba_pkg::OUT_W;

    gba_pkg::gba_state_t state_reg, state_next;

    logic [gba_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                  comp_reg, comp_next;
    logic [P-1:0]                mag_reg [gba_pkg::NCOMP];
    logic [P-1:0]                mag_next [gba_pkg::NCOMP];
    logic [gba_pkg::NCOMP-1:0]   neg_reg, neg_next;
    logic [gba_pkg::DEN_W-1:0]   mcand_reg, mcand_next;
    logic [gba_pkg::S_W-1:0]     mplier_reg, mplier_next;
    logic [gba_pkg::DEN_W-1:0]   prod_reg, prod_next;
    logic [gba_pkg::Q_W-1:0]     q_reg, q_next;
    logic [gba_pkg::SQ_IN_W-1:0] sqrem_reg, sqrem_next;
    logic [gba_pkg::SQ_IN_W-1:0] res_reg, res_next;
    logic [gba_pkg::SQ_IN_W-1:0] bit_reg, bit_next;
    logic [gba_pkg::DEN_W-1:0]   den_reg, den_next;
    logic [gba_pkg::NUM_W-1:0]   num_reg, num_next;
    logic [gba_pkg::DEN_W-1:0]   drem_reg, drem_next;
    logic [OW-1:0]               quo_reg, quo_next;
    logic                        big_reg, big_next;
    logic [OW-1:0]               acc_reg [gba_pkg::NCOMP];
    logic [OW-1:0]               acc_next [gba_pkg::NCOMP];
    logic                        zero_reg, zero_next;
    logic                        clip_reg, clip_next;

    logic [P-1:0]                pos_arr [gba_pkg::NCOMP];
    logic [P-1:0]                in_mag [gba_pkg::NCOMP];
    logic [gba_pkg::NCOMP-1:0]   in_neg;
    logic [gba_pkg::DEN_W-1:0]   mul_sum;

    assign pos_arr[0] = pos_x[P-1:0];
    assign pos_arr[1] = pos_y[P-1:0];
    assign pos_arr[2] = pos_z[P-1:0];

    always_comb
    begin
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            in_neg[k] = pos_arr[k][P-1];
            in_mag[k] = in_neg[k] ? (~pos_arr[k] + P'(1)) : pos_arr[k];
        end
    end

    // shared shift-add step
    assign mul_sum = mplier_reg[0] ? (prod_reg + mcand_reg) : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gba_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        comp_reg   <= comp_next;
        neg_reg    <= neg_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        q_reg      <= q_next;
        sqrem_reg  <= sqrem_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        den_reg    <= den_next;
        num_reg    <= num_next;
        drem_reg   <= drem_next;
        quo_reg    <= quo_next;
        big_reg    <= big_next;
        zero_reg   <= zero_next;
        clip_reg   <= clip_next;
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            mag_reg[k] <= mag_next[k];
            acc_reg[k] <= acc_next[k];
        end
    end

    always_comb
    begin
        logic [gba_pkg::SQ_IN_W-1:0] t;
        logic [gba_pkg::DEN_W:0]     sh;
        logic                        qbit;
        logic [OW-1:0]               lim;
        logic [OW-1:0]               m;
        logic                        ovf;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        comp_next   = comp_reg;
        neg_next    = neg_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        q_next      = q_reg;
        sqrem_next  = sqrem_reg;
        res_next    = res_reg;
        bit_next    = bit_reg;
        den_next    = den_reg;
        num_next    = num_reg;
        drem_next   = drem_reg;
        quo_next    = quo_reg;
        big_next    = big_reg;
        zero_next   = zero_reg;
        clip_next   = clip_reg;
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            mag_next[k] = mag_reg[k];
            acc_next[k] = acc_reg[k];
        end
        t    = res_reg + bit_reg;
        sh   = {drem_reg, num_reg[gba_pkg::NUM_W-1]};
        qbit = 1'b0;
        lim  = gba_pkg::SMIN;
        m    = quo_reg;
        ovf  = 1'b0;

        case (state_reg)
            gba_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    for (int k = 0; k < gba_pkg::NCOMP; k++)
                    begin
                        mag_next[k] = in_mag[k];
                    end
                    neg_next    = in_neg;
                    mcand_next  = gba_pkg::DEN_W'(in_mag[0]);
                    mplier_next = gba_pkg::S_W'(in_mag[0]);
                    prod_next   = '0;
                    cnt_next    = '0;
                    comp_next   = 2'd0;
                    clip_next   = 1'b0;
                    zero_next   = 1'b0;
                    state_next  = gba_pkg::ST_SQ;
                end
            end
            gba_pkg::ST_SQ:
            begin
                prod_next   = mul_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == gba_pkg::CNT_W'(P - 1))
                begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = gba_pkg::ST_CHK;
                    end
                    else
                    begin
                        comp_next   = comp_reg + 2'd1;
                        mcand_next  = gba_pkg::DEN_W'(mag_reg[comp_reg + 2'd1]);
                        mplier_next = gba_pkg::S_W'(mag_reg[comp_reg + 2'd1]);
                    end
                end
            end
            gba_pkg::ST_CHK:
            begin
                q_next = prod_reg[gba_pkg::Q_W-1:0];
                if (prod_reg == '0)
                begin
                    zero_next = 1'b1;
                    for (int k = 0; k < gba_pkg::NCOMP; k++)
                    begin
                        acc_next[k] = '0;
                    end
                    state_next = gba_pkg::ST_DONE;
                end
                else
                begin
                    sqrem_next = {prod_reg[gba_pkg::Q_W-1:0], 32'd0};
                    res_next   = '0;
                    bit_next   = {2'b01, {(gba_pkg::SQ_IN_W-2){1'b0}}};
                    cnt_next   = '0;
                    state_next = gba_pkg::ST_SQRT;
                end
            end
            gba_pkg::ST_SQRT:
            begin
                if (sqrem_reg >= t)
                begin
                    sqrem_next = sqrem_reg - t;
                    res_next   = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gba_pkg::CNT_W'(gba_pkg::SQ_ITER - 1))
                begin
                    mcand_next  = gba_pkg::DEN_W'(q_reg);
                    mplier_next = res_next[gba_pkg::S_W-1:0];
                    prod_next   = '0;
                    cnt_next    = '0;
                    state_next  = gba_pkg::ST_DEN;
                end
            end
            gba_pkg::ST_DEN:
            begin
                prod_next   = mul_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == gba_pkg::CNT_W'(gba_pkg::S_W - 1))
                begin
                    den_next    = mul_sum;
                    comp_next   = 2'd0;
                    mcand_next  = gba_pkg::DEN_W'(grav_param);
                    mplier_next = gba_pkg::S_W'(mag_reg[0]);
                    prod_next   = '0;
                    cnt_next    = '0;
                    state_next  = gba_pkg::ST_MUL;
                end
            end
            gba_pkg::ST_MUL:
            begin
                prod_next   = mul_sum;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == gba_pkg::CNT_W'(P - 1))
                begin
                    num_next   = {mul_sum[gba_pkg::PROD_W-1:0], {gba_pkg::NUM_SH{1'b0}}};
                    drem_next  = '0;
                    quo_next   = '0;
                    big_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = gba_pkg::ST_DIV;
                end
            end
            gba_pkg::ST_DIV:
            begin
                num_next = num_reg << 1;
                if (sh >= {1'b0, den_reg})
                begin
                    drem_next = gba_pkg::DEN_W'(sh - {1'b0, den_reg});
                    qbit      = 1'b1;
                end
                else
                begin
                    drem_next = sh[gba_pkg::DEN_W-1:0];
                end
                big_next = big_reg | quo_reg[OW-1];
                quo_next = {quo_reg[OW-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gba_pkg::CNT_W'(gba_pkg::NUM_W - 1))
                begin
                    lim = neg_reg[comp_reg] ? gba_pkg::SMAX : gba_pkg::SMIN;
                    m   = quo_next;
                    ovf = big_next || (m > lim);
                    if (ovf)
                    begin
                        m         = lim;
                        clip_next = 1'b1;
                    end
                    acc_next[comp_reg] = neg_reg[comp_reg] ? m : (~m + OW'(1));
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = gba_pkg::ST_DONE;
                    end
                    else
                    begin
                        comp_next   = comp_reg + 2'd1;
                        mcand_next  = gba_pkg::DEN_W'(grav_param);
                        mplier_next = gba_pkg::S_W'(mag_reg[comp_reg + 2'd1]);
                        prod_next   = '0;
                        state_next  = gba_pkg::ST_MUL;
                    end
                end
            end
            gba_pkg::ST_DONE:
            begin
                if (take)
                begin
                    state_next = gba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gba_pkg::ST_IDLE;
            end
        endcase
    end

    assign stat.done     = (state_reg == gba_pkg::ST_DONE);
    assign stat.zero_pos = zero_reg;
    assign stat.clip     = clip_reg;
    assign acc_x = acc_reg[0];
    assign acc_y = acc_reg[1];
    assign acc_z = acc_reg[2];

endmodule

// File: design/two_body_gravity_accel_unit.sv
// Top level of the two-body gravity acceleration unit: handshakes, GM register, kept sum.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid in_ready pos_x pos_y pos_z       | in
//          | clear_sum                                 |
//  out     | out_valid out_ready acc_* sum_*           | out
//          | zero_position saturated                   |
//  cfg     | cfg_valid cfg_ready cfg_data              | in
//
// Each word is worked on by the one bit-serial shift-add multiply, square-root and
// divide unit, one word at a time. The origin finishes early.
// in_ready is high whenever no word is being worked on; a finished result waits in
// the core while the output register still holds an untaken word.
// Reset clears the sum and loads GM with 398600441800000.
module two_body_gravity_accel_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [gba_pkg::POS_W-1:0] pos_x,
    input  logic [gba_pkg::POS_W-1:0] pos_y,
    input  logic [gba_pkg::POS_W-1:0] pos_z,
    input  logic                      clear_sum,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [gba_pkg::OUT_W-1:0] acc_x,
    output logic [gba_pkg::OUT_W-1:0] acc_y,
    output logic [gba_pkg::OUT_W-1:0] acc_z,
    output logic [gba_pkg::OUT_W-1:0] sum_x,
    output logic [gba_pkg::OUT_W-1:0] sum_y,
    output logic [gba_pkg::OUT_W-1:0] sum_z,
    output logic                      zero_position,
    output logic                      saturated,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [gba_pkg::GP_W-1:0]  cfg_data
);

    localparam int OW = gba_pkg::OUT_W;

    logic                     busy_reg, busy_next;
    logic                     clear_reg, clear_next;
    logic                     out_valid_reg, out_valid_next;
    logic [gba_pkg::GP_W-1:0] gp_reg, gp_next;
    logic [OW-1:0]            sum_reg [gba_pkg::NCOMP];
    logic [OW-1:0]            sum_next [gba_pkg::NCOMP];
    logic [OW-1:0]            acc_o_reg [gba_pkg::NCOMP];
    logic [OW-1:0]            acc_o_next [gba_pkg::NCOMP];
    logic                     zero_o_reg, zero_o_next;
    logic                     sat_o_reg, sat_o_next;

    gba_pkg::gba_stat_t       stat;
    logic [OW-1:0]            core_acc [gba_pkg::NCOMP];
    logic                     start;
    logic                     take;

    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign start     = in_valid && in_ready;
    assign take      = stat.done && (!out_valid_reg || out_ready);

    gba_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .take       (take),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .grav_param (gp_reg),
        .stat       (stat),
        .acc_x      (core_acc[0]),
        .acc_y      (core_acc[1]),
        .acc_z      (core_acc[2])
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            gp_reg        <= gba_pkg::GP_RESET;
            for (int k = 0; k < gba_pkg::NCOMP; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            gp_reg        <= gp_next;
            for (int k = 0; k < gba_pkg::NCOMP; k++)
            begin
                sum_reg[k] <= sum_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        clear_reg  <= clear_next;
        zero_o_reg <= zero_o_next;
        sat_o_reg  <= sat_o_next;
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            acc_o_reg[k] <= acc_o_next[k];
        end
    end

    always_comb
    begin
        gba_pkg::gba_sat_t r;
        logic              clip;
        logic [OW-1:0]     base;

        busy_next      = busy_reg;
        clear_next     = clear_reg;
        out_valid_next = out_valid_reg;
        gp_next        = gp_reg;
        zero_o_next    = zero_o_reg;
        sat_o_next     = sat_o_reg;
        clip           = stat.clip;
        r              = '0;
        base           = '0;
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            sum_next[k]   = sum_reg[k];
            acc_o_next[k] = acc_o_reg[k];
        end

        if (cfg_valid && cfg_ready)
        begin
            gp_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (start)
        begin
            busy_next  = 1'b1;
            clear_next = clear_sum;
        end
        if (take)
        begin
            for (int k = 0; k < gba_pkg::NCOMP; k++)
            begin
                base          = clear_reg ? '0 : sum_reg[k];
                r             = gba_pkg::sat_add(base, core_acc[k]);
                sum_next[k]   = r.sum;
                clip          = clip | r.clip;
                acc_o_next[k] = core_acc[k];
            end
            zero_o_next    = stat.zero_pos;
            sat_o_next     = clip;
            out_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign acc_x         = acc_o_reg[0];
    assign acc_y         = acc_o_reg[1];
    assign acc_z         = acc_o_reg[2];
    assign sum_x         = sum_reg[0];
    assign sum_y         = sum_reg[1];
    assign sum_z         = sum_reg[2];
    assign zero_position = zero_o_reg;
    assign saturated     = sat_o_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> busy_reg)
        else $error("core result with no word in flight");

    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> out_valid_reg)
        else $error("word retired without a result");

    a_origin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_position |-> acc_x == '0 && acc_y == '0 && acc_z == '0)
        else $error("origin gave non-zero acceleration");

endmodule

// File: tb/two_body_gravity_accel_unit_chk.sv
// Checker for the two-body gravity acceleration unit: own prediction and result comparison.
`timescale 1ns / 1ps
module two_body_gravity_accel_unit_chk (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [gba_pkg::POS_W-1:0] pos_x,
    input  logic [gba_pkg::POS_W-1:0] pos_y,
    input  logic [gba_pkg::POS_W-1:0] pos_z,
    input  logic                      clear_sum,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [gba_pkg::OUT_W-1:0] acc_x,
    input  logic [gba_pkg::OUT_W-1:0] acc_y,
    input  logic [gba_pkg::OUT_W-1:0] acc_z,
    input  logic [gba_pkg::OUT_W-1:0] sum_x,
    input  logic [gba_pkg::OUT_W-1:0] sum_y,
    input  logic [gba_pkg::OUT_W-1:0] sum_z,
    input  logic                      zero_position,
    input  logic                      saturated,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [gba_pkg::GP_W-1:0]  cfg_data,
    output int                        errors,
    output int                        pending,
    output int                        n_words,
    output int                        n_results,
    output int                        n_origin,
    output int                        n_clipped
);

    typedef logic [255:0] wide_t;

    typedef struct {
        logic [gba_pkg::OUT_W-1:0] acc [gba_pkg::NCOMP];
        logic [gba_pkg::OUT_W-1:0] sum [gba_pkg::NCOMP];
        logic                      origin;
        logic                      clip;
    } accel_word_t;

    accel_word_t               accel_q [$];
    logic [gba_pkg::GP_W-1:0]  gm;
    logic [gba_pkg::OUT_W-1:0] vsum [gba_pkg::NCOMP];

    assign pending = accel_q.size();

    function automatic wide_t int_sqrt(input wide_t n);
        wide_t res, cand;
        res = '0;
        for (int i = 127; i >= 0; i--)
        begin
            cand = res | (wide_t'(1) << i);
            if (cand * cand <= n)
                res = cand;
        end
        return res;
    endfunction

    task automatic predict_accel(input logic [gba_pkg::POS_W-1:0] p [gba_pkg::NCOMP],
                                 input logic clr, output accel_word_t e);
        logic [gba_pkg::POS_W-1:0] mag [gba_pkg::NCOMP];
        logic [gba_pkg::OUT_W-1:0] m, lim, s;
        wide_t                     q, den, quo;
        e.clip = 1'b0;
        q = '0;
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            mag[k] = p[k][gba_pkg::POS_W-1] ? -p[k] : p[k];
            q += wide_t'(mag[k]) * wide_t'(mag[k]);
        end
        e.origin = (q == 0);
        for (int k = 0; k < gba_pkg::NCOMP; k++)
            e.acc[k] = '0;
        if (!e.origin)
        begin
            den = q * int_sqrt(q << 32);
            for (int k = 0; k < gba_pkg::NCOMP; k++)
            begin
                quo = ((wide_t'(gm) << gba_pkg::NUM_SH) * wide_t'(mag[k])) / den;
                m   = quo[63:0];
                lim = p[k][gba_pkg::POS_W-1] ? gba_pkg::SMAX : gba_pkg::SMIN;
                if (|quo[255:64] || m > lim)
                begin
                    m = lim;
                    e.clip = 1'b1;
                end
                e.acc[k] = p[k][gba_pkg::POS_W-1] ? m : -m;
            end
        end
        if (clr)
            for (int k = 0; k < gba_pkg::NCOMP; k++)
                vsum[k] = '0;
        for (int k = 0; k < gba_pkg::NCOMP; k++)
        begin
            s = vsum[k] + e.acc[k];
            if (vsum[k][gba_pkg::OUT_W-1] == e.acc[k][gba_pkg::OUT_W-1]
                && s[gba_pkg::OUT_W-1] != vsum[k][gba_pkg::OUT_W-1])
            begin
                s = vsum[k][gba_pkg::OUT_W-1] ? gba_pkg::SMIN : gba_pkg::SMAX;
                e.clip = 1'b1;
            end
            vsum[k] = s;
            e.sum[k] = s;
        end
    endtask

    function automatic int field_bad(input string name,
                                     input logic [gba_pkg::OUT_W-1:0] exp_v,
                                     input logic [gba_pkg::OUT_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        accel_word_t               e;
        logic [gba_pkg::POS_W-1:0] p [gba_pkg::NCOMP];
        int                        bad;
        if (!rst_n)
        begin
            gm <= gba_pkg::GP_RESET;
            for (int k = 0; k < gba_pkg::NCOMP; k++)
                vsum[k] = '0;
            accel_q.delete();
            errors <= 0;
            n_words <= 0;
            n_results <= 0;
            n_origin <= 0;
            n_clipped <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                gm <= cfg_data;
            if (in_valid && in_ready)
            begin
                p[0] = pos_x;
                p[1] = pos_y;
                p[2] = pos_z;
                predict_accel(p, clear_sum, e);
                accel_q.push_back(e);
                n_words <= n_words + 1;
                n_origin <= n_origin + e.origin;
                n_clipped <= n_clipped + e.clip;
            end
            if (out_valid && out_ready)
            begin
                n_results <= n_results + 1;
                if (accel_q.size() == 0)
                begin
                    $display("%0t: unexpected result word, acc_x %h", $time, acc_x);
                    errors <= errors + 1;
                end
                else
                begin
                    e = accel_q.pop_front();
                    bad = field_bad("acc_x", e.acc[0], acc_x)
                        + field_bad("acc_y", e.acc[1], acc_y)
                        + field_bad("acc_z", e.acc[2], acc_z)
                        + field_bad("sum_x", e.sum[0], sum_x)
                        + field_bad("sum_y", e.sum[1], sum_y)
                        + field_bad("sum_z", e.sum[2], sum_z)
                        + field_bad("zero_position", gba_pkg::OUT_W'(e.origin),
                                    gba_pkg::OUT_W'(zero_position))
                        + field_bad("saturated", gba_pkg::OUT_W'(e.clip),
                                    gba_pkg::OUT_W'(saturated));
                    if (bad != 0)
                        errors <= errors + 1;
                end
            end
        end
    end

endmodule

// File: tb/two_body_gravity_accel_unit_tb.sv
// Testbench top for the two-body gravity acceleration unit: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module two_body_gravity_accel_unit_tb;

    localparam int PHASE_WORDS = 166;
    localparam int HOLD_CYCLES = 3000;
    localparam int SETTLE      = 1000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [gba_pkg::POS_W-1:0] pos_x = '0;
    logic [gba_pkg::POS_W-1:0] pos_y = '0;
    logic [gba_pkg::POS_W-1:0] pos_z = '0;
    logic                      clear_sum = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [gba_pkg::OUT_W-1:0] acc_x, acc_y, acc_z, sum_x, sum_y, sum_z;
    logic                      zero_position, saturated;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [gba_pkg::GP_W-1:0]  cfg_data = '0;
    int                        errors, pending, n_words, n_results, n_origin, n_clipped;
    logic                      held = 1'b0;

    localparam logic [gba_pkg::POS_W-1:0] PMAX = {1'b0, {(gba_pkg::POS_W-1){1'b1}}};
    localparam logic [gba_pkg::POS_W-1:0] PMIN = {1'b1, {(gba_pkg::POS_W-1){1'b0}}};
    localparam logic [gba_pkg::GP_W-1:0]  GMAX = '1;

    always #1 clk = ~clk;

    two_body_gravity_accel_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .clear_sum(clear_sum),
        .out_valid(out_valid), .out_ready(out_ready),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .sum_x(sum_x), .sum_y(sum_y), .sum_z(sum_z),
        .zero_position(zero_position), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    two_body_gravity_accel_unit_chk u_chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .clear_sum(clear_sum),
        .out_valid(out_valid), .out_ready(out_ready),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .sum_x(sum_x), .sum_y(sum_y), .sum_z(sum_z),
        .zero_position(zero_position), .saturated(saturated),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .n_words(n_words), .n_results(n_results),
        .n_origin(n_origin), .n_clipped(n_clipped)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 6);
        return $urandom_range(20, 300);
    endfunction

    function automatic logic [gba_pkg::POS_W-1:0] rand_pos();
        logic [gba_pkg::POS_W-1:0] v;
        int                        r;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = '0;
        else if (r == 1)
        begin
            case ($urandom_range(0, 3))
                0: v = PMAX;
                1: v = PMIN;
                2: v = gba_pkg::POS_W'(1);
                default: v = '1;
            endcase
        end
        else if (r < 6)
        begin
            v = gba_pkg::POS_W'($urandom >> $urandom_range(0, 31));
            if ($urandom_range(0, 1))
                v = -v;
        end
        else
            v = gba_pkg::POS_W'({$urandom, $urandom});
        return v;
    endfunction

    task automatic send_word(input logic [gba_pkg::POS_W-1:0] x,
                             input logic [gba_pkg::POS_W-1:0] y,
                             input logic [gba_pkg::POS_W-1:0] z, input logic clr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        clear_sum <= clr;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_gm(input logic [gba_pkg::GP_W-1:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // receiver pacing, with one long hold-off midway
    initial
    begin
        int r;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && n_results >= 300)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                out_ready <= (r < 60);
                if (r < 60)
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                else if (r < 95)
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                else
                    repeat ($urandom_range(30, 400)) @(posedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic [gba_pkg::GP_W-1:0] gm_set [5];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset GM
        send_word('0, '0, '0, 1'b0);
        send_word(48'd1, '0, '0, 1'b0);
        send_word('1, '0, '0, 1'b0);
        send_word('0, '0, PMAX, 1'b0);
        send_word(PMIN, PMIN, PMIN, 1'b1);
        send_word(PMAX, PMAX, PMAX, 1'b0);
        send_word(48'd7000000, '0, '0, 1'b1);
        send_word(-48'd4000000, 48'd3000000, 48'd5000000, 1'b0);
        send_word(PMIN, '0, '0, 1'b0);
        send_word('0, '0, '0, 1'b1);
        // largest GM: clipped accelerations, then the sum runs into its limit
        write_gm(GMAX);
        send_word(48'd1, '0, '0, 1'b1);
        send_word('0, '1, '0, 1'b0);
        send_word(48'd1, 48'd1, '1, 1'b1);
        send_word(48'd1, 48'd1, '1, 1'b0);
        send_word(48'd1, 48'd1, '1, 1'b0);
        send_word(PMAX, PMIN, 48'd1, 1'b0);
        // zero GM: no acceleration away from the origin
        write_gm('0);
        send_word(48'd12345, '1, PMIN, 1'b0);
        send_word('0, '0, '0, 1'b0);
        send_word(PMAX, 48'd99, '0, 1'b1);

        gm_set[0] = gba_pkg::GP_RESET;
        gm_set[1] = gba_pkg::GP_W'({$urandom, $urandom});
        gm_set[2] = GMAX;
        gm_set[3] = gba_pkg::GP_W'($urandom_range(1, 1000));
        gm_set[4] = '0;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_gm(gm_set[ph]);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(rand_pos(), rand_pos(), rand_pos(), $urandom_range(0, 7) == 0);
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
        $display("Covered %0d position words, %0d results, %0d at the origin, %0d clipped,",
                 n_words, n_results, n_origin, n_clipped);
        $display("across reset, random, small, zero and full-scale GM values.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
